// ===== src/qmn_pkg.sv =====
// ----------------------------------------------------------------------------
// qmn_pkg
// Types and constants shared by the normalized quaternion product datapath.
// ----------------------------------------------------------------------------
package qmn_pkg;

  // Component format: signed, CW bits with FB fraction bits.
  localparam int CW    = 16;
  localparam int FB    = 14;
  // Products are pre-shifted only when they could overflow the four-term sums.
  localparam int PRE   = (2 * CW > 60) ? (2 * CW - 60) : 0;
  localparam int PW    = 2 * CW - PRE;       // shifted partial product
  localparam int SW    = PW + 2;             // four-term sum
  localparam int MW    = SW;                 // magnitude of a sum
  localparam int PSW   = $clog2(MW);         // leading-one position
  localparam int NB    = 30;                 // normalized magnitude, msb at NB-1
  localparam int RADW  = 2 * NB + 2;         // sum of four squares
  localparam int RTW   = NB + 1;             // square root
  localparam int REMW  = RTW + 3;            // square root remainder
  localparam int NUMW  = NB + FB + 1;        // rounded dividend
  localparam int QB    = FB + 2;             // quotient bits
  localparam int DREMW = RTW + 1;            // division remainder
  localparam int LW    = ((QB > CW) ? QB : CW) + 1;

  typedef struct packed {
    logic signed [CW-1:0] p_w;
    logic signed [CW-1:0] p_x;
    logic signed [CW-1:0] p_y;
    logic signed [CW-1:0] p_z;
    logic signed [CW-1:0] q_w;
    logic signed [CW-1:0] q_x;
    logic signed [CW-1:0] q_y;
    logic signed [CW-1:0] q_z;
  } qmn_in_t;

  typedef struct packed {
    logic signed [CW-1:0] r_w;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_z;
    logic                 degenerate;
  } qmn_out_t;

  // Data handed from one square root cell to the next.
  typedef struct packed {
    logic [RADW-1:0]    rad;
    logic [REMW-1:0]    rem;
    logic [RTW-1:0]     root;
    logic [3:0][NB-1:0] nm;
    logic [3:0]         neg;
    logic               zero;
  } qmn_sq_t;

  // Data handed from one divider cell to the next, four lanes wide.
  typedef struct packed {
    logic [3:0][QB-1:0]    lo;
    logic [3:0][DREMW-1:0] rem;
    logic [3:0][QB-1:0]    quo;
    logic [RTW-1:0]        den;
    logic [3:0]            neg;
    logic                  zero;
  } qmn_dv_t;

endpackage

// ===== src/quaternion_multiply_normalize.sv =====
// ----------------------------------------------------------------------------
// quaternion_multiply_normalize
// Hamilton product of two Q2.14 quaternions, scaled to unit length.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready carries p and q; the output channel
// out_valid/out_ready carries the normalized product and a degenerate flag
// that is set, with all components zero, when the product is zero.
// One pair is taken per clock while in_ready is high. From the input
// transfer to out_valid a result passes the product, sum, magnitude,
// leading-one, normalize, square and sum-of-squares stages, a row of 31
// square root cells that each give one root bit, a setup stage, a row of
// 16 divider cells that each give one quotient bit, and the output register.
// When the receiver stalls, the output register holds its result and the
// cell rows keep moving until a valid item reaches the end of the row; only
// then does in_ready drop. The whole row moves as one, so gaps between items
// are kept, not squeezed out.
// Synchronous reset clears all valid flags; items in flight are dropped.
// ----------------------------------------------------------------------------
module quaternion_multiply_normalize (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qmn_pkg::qmn_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output qmn_pkg::qmn_out_t out_data
);

  localparam int NSQ = qmn_pkg::RTW;
  localparam int NST = 7 + NSQ + 1 + qmn_pkg::QB;

  logic [NST-1:0] vld_r;
  logic           out_valid_r;
  logic           out_free;
  logic           en;
  qmn_pkg::qmn_out_t out_data_r;
  qmn_pkg::qmn_out_t res;

  assign out_free = !out_valid_r || out_ready;
  assign en       = out_free || !vld_r[NST-1];
  assign in_ready = en;

  // Stage 0: sixteen partial products.
  logic signed [qmn_pkg::CW-1:0]   a [4];
  logic signed [qmn_pkg::CW-1:0]   b [4];
  logic signed [2*qmn_pkg::CW-1:0] prod [16];
  logic signed [qmn_pkg::PW-1:0]   pp_r [16];

  assign a[0] = in_data.p_w;
  assign a[1] = in_data.p_x;
  assign a[2] = in_data.p_y;
  assign a[3] = in_data.p_z;
  assign b[0] = in_data.q_w;
  assign b[1] = in_data.q_x;
  assign b[2] = in_data.q_y;
  assign b[3] = in_data.q_z;

  for (genvar i = 0; i < 4; i++) begin : g_pi
    for (genvar j = 0; j < 4; j++) begin : g_pj
      assign prod[i*4+j] = a[i] * b[j];
      always_ff @(posedge clk) begin
        if (en) begin
          pp_r[i*4+j] <= qmn_pkg::PW'(prod[i*4+j] >>> qmn_pkg::PRE);
        end
      end
    end
  end

  // Stage 1: the four components of the product.
  logic signed [qmn_pkg::SW-1:0] e [16];
  logic signed [qmn_pkg::SW-1:0] c_r [4];

  for (genvar k = 0; k < 16; k++) begin : g_ext
    assign e[k] = qmn_pkg::SW'(pp_r[k]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r[0] <= e[0] - e[5] - e[10] - e[15];
      c_r[1] <= e[1] + e[4] + e[11] - e[14];
      c_r[2] <= e[2] - e[7] + e[8] + e[13];
      c_r[3] <= e[3] + e[6] - e[9] + e[12];
    end
  end

  // Stage 2: sign and magnitude.
  logic [qmn_pkg::MW-1:0] mag_r [4];
  logic [3:0]             neg2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        neg2_r[i] <= c_r[i][qmn_pkg::SW-1];
        mag_r[i]  <= c_r[i][qmn_pkg::SW-1] ? (~c_r[i] + 1'b1) : c_r[i];
      end
    end
  end

  // Stage 3: leading one of the largest magnitude, found from their OR.
  logic [qmn_pkg::MW-1:0]  orv;
  logic [qmn_pkg::PSW-1:0] msb;
  logic [qmn_pkg::PSW-1:0] msb_r;
  logic                    zero3_r;
  logic [qmn_pkg::MW-1:0]  mag3_r [4];
  logic [3:0]              neg3_r;

  always_comb begin
    orv = mag_r[0] | mag_r[1] | mag_r[2] | mag_r[3];
    msb = '0;
    for (int k = 0; k < qmn_pkg::MW; k++) begin
      if (orv[k]) begin
        msb = qmn_pkg::PSW'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      msb_r   <= msb;
      zero3_r <= (orv == '0);
      mag3_r  <= mag_r;
      neg3_r  <= neg2_r;
    end
  end

  // Stage 4: shift every magnitude so the largest has its msb at NB-1.
  logic [qmn_pkg::MW+qmn_pkg::NB-2:0] wide [4];
  logic [qmn_pkg::NB-1:0]             nm4_r [4];
  logic [3:0]                         neg4_r;
  logic                               zero4_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      wide[i] = {mag3_r[i], {(qmn_pkg::NB-1){1'b0}}} >> msb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        nm4_r[i] <= wide[i][qmn_pkg::NB-1:0];
      end
      neg4_r  <= neg3_r;
      zero4_r <= zero3_r;
    end
  end

  // Stage 5: squares.
  logic [2*qmn_pkg::NB-1:0] sqv_r [4];
  logic [qmn_pkg::NB-1:0]   nm5_r [4];
  logic [3:0]               neg5_r;
  logic                     zero5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sqv_r[i] <= nm4_r[i] * nm4_r[i];
      end
      nm5_r   <= nm4_r;
      neg5_r  <= neg4_r;
      zero5_r <= zero4_r;
    end
  end

  // Stage 6: sum of squares, packed for the square root row.
  qmn_pkg::qmn_sq_t sq_chain [NSQ+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sq_chain[0].rad <= qmn_pkg::RADW'(sqv_r[0]) + qmn_pkg::RADW'(sqv_r[1])
                       + qmn_pkg::RADW'(sqv_r[2]) + qmn_pkg::RADW'(sqv_r[3]);
      sq_chain[0].rem  <= '0;
      sq_chain[0].root <= '0;
      for (int i = 0; i < 4; i++) begin
        sq_chain[0].nm[i] <= nm5_r[i];
      end
      sq_chain[0].neg  <= neg5_r;
      sq_chain[0].zero <= zero5_r;
    end
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sq
    qmn_sqrt_cell u_cell (
      .clk (clk),
      .en  (en),
      .d   (sq_chain[k]),
      .q   (sq_chain[k+1])
    );
  end

  // Divider setup: dividend is the magnitude scaled up, plus half the norm.
  qmn_pkg::qmn_sq_t          sq_end;
  logic [qmn_pkg::NUMW-1:0]  num [4];
  qmn_pkg::qmn_dv_t          dv_chain [qmn_pkg::QB+1];

  assign sq_end = sq_chain[NSQ];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      num[i] = qmn_pkg::NUMW'({sq_end.nm[i], {qmn_pkg::FB{1'b0}}})
             + qmn_pkg::NUMW'(sq_end.root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        dv_chain[0].lo[i]  <= num[i][qmn_pkg::QB-1:0];
        dv_chain[0].rem[i] <= qmn_pkg::DREMW'(num[i][qmn_pkg::NUMW-1:qmn_pkg::QB]);
        dv_chain[0].quo[i] <= '0;
      end
      dv_chain[0].den  <= sq_end.root;
      dv_chain[0].neg  <= sq_end.neg;
      dv_chain[0].zero <= sq_end.zero;
    end
  end

  for (genvar k = 0; k < qmn_pkg::QB; k++) begin : g_dv
    qmn_div_cell u_cell (
      .clk (clk),
      .en  (en),
      .d   (dv_chain[k]),
      .q   (dv_chain[k+1])
    );
  end

  // Saturate, restore the sign, and force zero on a zero product.
  qmn_pkg::qmn_dv_t         dv_end;
  logic [qmn_pkg::LW-1:0]   half;
  logic [qmn_pkg::LW-1:0]   lim;
  logic [qmn_pkg::LW-1:0]   qx;
  logic [qmn_pkg::LW-1:0]   sat;
  logic [qmn_pkg::LW-1:0]   sv;
  logic [qmn_pkg::CW-1:0]   rv [4];

  assign dv_end = dv_chain[qmn_pkg::QB];
  assign half   = qmn_pkg::LW'(1) << (qmn_pkg::CW - 1);

  always_comb begin
    lim = '0;
    qx  = '0;
    sat = '0;
    sv  = '0;
    for (int i = 0; i < 4; i++) begin
      lim   = dv_end.neg[i] ? half : (half - 1'b1);
      qx    = qmn_pkg::LW'(dv_end.quo[i]);
      sat   = (qx > lim) ? lim : qx;
      sv    = dv_end.neg[i] ? (~sat + 1'b1) : sat;
      rv[i] = dv_end.zero ? '0 : sv[qmn_pkg::CW-1:0];
    end
    res.r_w        = rv[0];
    res.r_x        = rv[1];
    res.r_y        = rv[2];
    res.r_z        = rv[3];
    res.degenerate = dv_end.zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        vld_r <= {vld_r[NST-2:0], in_valid};
      end
      if (out_free) begin
        out_valid_r <= vld_r[NST-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/qmn_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// qmn_sqrt_cell
// One digit of a restoring square root; produces one root bit per cell.
// ----------------------------------------------------------------------------
module qmn_sqrt_cell (
  input  logic             clk,
  input  logic             en,
  input  qmn_pkg::qmn_sq_t d,
  output qmn_pkg::qmn_sq_t q
);

  qmn_pkg::qmn_sq_t             sq_nxt;
  qmn_pkg::qmn_sq_t             sq_r;
  logic [qmn_pkg::REMW-1:0]     t;
  logic [qmn_pkg::REMW-1:0]     trial;
  logic                         ge;

  always_comb begin
    t      = {d.rem[qmn_pkg::REMW-3:0], d.rad[qmn_pkg::RADW-1 -: 2]};
    trial  = qmn_pkg::REMW'({d.root, 2'b01});
    ge     = (t >= trial);
    sq_nxt = d;
    sq_nxt.rad  = {d.rad[qmn_pkg::RADW-3:0], 2'b00};
    sq_nxt.rem  = ge ? (t - trial) : t;
    sq_nxt.root = {d.root[qmn_pkg::RTW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sq_nxt;
    end
  end

  assign q = sq_r;

endmodule

// ===== src/qmn_div_cell.sv =====
// ----------------------------------------------------------------------------
// qmn_div_cell
// One quotient bit of a restoring division for each of the four lanes.
// ----------------------------------------------------------------------------
module qmn_div_cell (
  input  logic             clk,
  input  logic             en,
  input  qmn_pkg::qmn_dv_t d,
  output qmn_pkg::qmn_dv_t q
);

  qmn_pkg::qmn_dv_t          dv_nxt;
  qmn_pkg::qmn_dv_t          dv_r;
  logic [qmn_pkg::DREMW-1:0] den;
  logic [qmn_pkg::DREMW-1:0] t;
  logic                      ge;

  always_comb begin
    dv_nxt = d;
    den    = qmn_pkg::DREMW'(d.den);
    t      = '0;
    ge     = 1'b0;
    for (int i = 0; i < 4; i++) begin
      // The remainder stays below the divisor, so its top bit is always zero.
      t  = {d.rem[i][qmn_pkg::DREMW-2:0], d.lo[i][qmn_pkg::QB-1]};
      ge = (t >= den);
      dv_nxt.rem[i] = ge ? (t - den) : t;
      dv_nxt.lo[i]  = {d.lo[i][qmn_pkg::QB-2:0], 1'b0};
      dv_nxt.quo[i] = {d.quo[i][qmn_pkg::QB-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r <= dv_nxt;
    end
  end

  assign q = dv_r;

endmodule

// ===== src/qmn_checker.sv =====
// ----------------------------------------------------------------------------
// qmn_checker
// Port-level checks for the normalized quaternion product block.
// ----------------------------------------------------------------------------
module qmn_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input qmn_pkg::qmn_out_t out_data
);

  // A result held by the receiver must not vanish.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("out_data changed while stalled");

  // A degenerate result carries an all-zero quaternion.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.r_w == '0 && out_data.r_x == '0 &&
      out_data.r_y == '0 && out_data.r_z == '0)
    else $error("degenerate result with nonzero components");

  // Reset flushes the pipeline.
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

endmodule

bind quaternion_multiply_normalize qmn_checker u_qmn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the normalized Hamilton quaternion product.
// ----------------------------------------------------------------------------
// Directed quaternion pairs cover the component extremes, a zero product and
// saturating cases. Random pairs follow: full-range, small, sparse and
// extreme components, and products that vanish. Both channels idle at
// random. Every output transfer is compared with a bit-accurate predictor.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 56;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  qmn_pkg::qmn_in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  qmn_pkg::qmn_out_t out_data;

  qmn_pkg::qmn_out_t expected_products[$];
  int       mismatch_count = 0;
  int       unexpected_count = 0;
  int       product_count = 0;
  int       degenerate_count = 0;
  bit       stall_enable = 1'b1;

  always #5 clk = ~clk;

  quaternion_multiply_normalize dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Floor-shifted exact partial product.
  function automatic longint partial(longint a, longint b);
    return (a * b) >>> qmn_pkg::PRE;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic qmn_pkg::qmn_out_t unit_product(qmn_pkg::qmn_in_t d);
    longint      a[4];
    longint      b[4];
    longint      c[4];
    logic [63:0] m[4];
    logic [63:0] maxm;
    logic [63:0] sum;
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] lim;
    bit          neg[4];
    logic [qmn_pkg::CW-1:0] comp[4];
    qmn_pkg::qmn_out_t res;
    a = '{d.p_w, d.p_x, d.p_y, d.p_z};
    b = '{d.q_w, d.q_x, d.q_y, d.q_z};
    c[0] = partial(a[0], b[0]) - partial(a[1], b[1]) - partial(a[2], b[2])
         - partial(a[3], b[3]);
    c[1] = partial(a[0], b[1]) + partial(a[1], b[0]) + partial(a[2], b[3])
         - partial(a[3], b[2]);
    c[2] = partial(a[0], b[2]) - partial(a[1], b[3]) + partial(a[2], b[0])
         + partial(a[3], b[1]);
    c[3] = partial(a[0], b[3]) + partial(a[1], b[2]) - partial(a[2], b[1])
         + partial(a[3], b[0]);
    maxm = 0;
    for (int i = 0; i < 4; i++) begin
      neg[i] = c[i] < 0;
      m[i] = neg[i] ? -c[i] : c[i];
      if (m[i] > maxm) maxm = m[i];
    end
    res = '0;
    if (maxm == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    while (maxm >= (64'd1 << 30)) begin
      maxm >>= 1;
      for (int i = 0; i < 4; i++) m[i] >>= 1;
    end
    while (maxm < (64'd1 << 29)) begin
      maxm <<= 1;
      for (int i = 0; i < 4; i++) m[i] <<= 1;
    end
    sum = 0;
    for (int i = 0; i < 4; i++) sum += m[i] * m[i];
    n = root64(sum);
    for (int i = 0; i < 4; i++) begin
      r = ((m[i] << qmn_pkg::FB) + (n >> 1)) / n;
      lim = neg[i] ? (64'd1 << (qmn_pkg::CW - 1)) : (64'd1 << (qmn_pkg::CW - 1)) - 1;
      if (r > lim) r = lim;
      comp[i] = qmn_pkg::CW'(neg[i] ? -r : r);
    end
    res.r_w = comp[0];
    res.r_x = comp[1];
    res.r_y = comp[2];
    res.r_z = comp[3];
    return res;
  endfunction

  // In_valid is dropped only when a wait follows, so a new transfer can
  // start in the cycle right after the previous one.
  task automatic send_pair(qmn_pkg::qmn_in_t d);
    int gap;
    gap = stall_enable ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_products.push_back(unit_product(d));
  endtask

  task automatic check_product(qmn_pkg::qmn_out_t got);
    qmn_pkg::qmn_out_t want;
    if (expected_products.size() == 0) begin
      unexpected_count++;
      if (mismatch_count + unexpected_count <= 10)
        $display("ERROR: unexpected output transfer %h", got);
      return;
    end
    want = expected_products.pop_front();
    product_count++;
    if (want.degenerate) degenerate_count++;
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count + unexpected_count <= 10)
        $display("ERROR: w %0d/%0d x %0d/%0d y %0d/%0d z %0d/%0d deg %b/%b (exp/act)",
                 want.r_w, got.r_w, want.r_x, got.r_x, want.r_y, got.r_y,
                 want.r_z, got.r_z, want.degenerate, got.degenerate);
    end
  endtask

  // Receiver: a new wait is drawn after every output transfer.
  initial begin
    int hold;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      hold = stall_enable ? $urandom_range(0, 5) : 0;
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      check_product(out_data);
    end
  end

  function automatic logic [qmn_pkg::CW-1:0] rand_comp(int mode);
    case (mode)
      0: return qmn_pkg::CW'($urandom());
      1: return qmn_pkg::CW'($urandom_range(0, 64) - 32);
      2: return ($urandom_range(0, 3) == 0) ? qmn_pkg::CW'($urandom()) : '0;
      default: return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7fff;
    endcase
  endfunction

  task automatic test_directed();
    qmn_pkg::qmn_in_t d;
    logic [qmn_pkg::CW-1:0] v[6];
    v = '{16'h0000, 16'h4000, 16'h7fff, 16'h8000, 16'hc000, 16'h0001};
    send_pair('0);
    send_pair({16'h4000, 48'd0, 16'h4000, 48'd0});
    send_pair({16'h4000, 48'd0, 64'd0});
    for (int i = 0; i < 6; i++) begin
      d = {8{v[i]}};
      send_pair(d);
      d = {v[i], v[(i + 1) % 6], v[(i + 2) % 6], v[(i + 3) % 6],
           v[(i + 4) % 6], v[(i + 5) % 6], v[i], v[(i + 3) % 6]};
      send_pair(d);
    end
    send_pair({16'h0001, 48'd0, 16'h0001, 48'd0});
    send_pair({{4{16'h8000}}, {4{16'h8000}}});
    send_pair({{4{16'h7fff}}, {4{16'h8000}}});
    // Only x components: the product is a pure scalar.
    send_pair({16'd0, 16'h2000, 32'd0, 16'd0, 16'h2000, 32'd0});
  endtask

  task automatic test_random(int count);
    qmn_pkg::qmn_in_t d;
    int mode;
    for (int k = 0; k < count; k++) begin
      if (k == count / 2) stall_enable = 1'b0;
      if (k == count / 2 + 100) stall_enable = 1'b1;
      mode = $urandom_range(0, 9);
      d.p_w = rand_comp(mode % 4); d.p_x = rand_comp(mode % 4);
      d.p_y = rand_comp(mode % 4); d.p_z = rand_comp(mode % 4);
      d.q_w = rand_comp(mode % 4); d.q_x = rand_comp(mode % 4);
      d.q_y = rand_comp(mode % 4); d.q_z = rand_comp(mode % 4);
      if (mode == 9) d[8*qmn_pkg::CW-1:4*qmn_pkg::CW] = '0;
      send_pair(d);
    end
  endtask

  initial begin
    int waited;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1030);
    in_valid <= 1'b0;
    waited = 0;
    while (expected_products.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d normalized products, %0d of them degenerate.",
             product_count, degenerate_count);
    if (mismatch_count == 0 && unexpected_count == 0 && expected_products.size() == 0)
      $display("PASS quaternion_multiply_normalize");
    else
      $display("FAIL quaternion_multiply_normalize");
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL quaternion_multiply_normalize");
    $finish;
  end

endmodule

// ===== sim.f =====
src/qmn_pkg.sv
src/qmn_sqrt_cell.sv
src/qmn_div_cell.sv
src/quaternion_multiply_normalize.sv
src/qmn_checker.sv
sim/tb.sv
